/* src/ple_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine package
// Shared widths, request and status codes, and the per-cell control word.
// ----------------------------------------------------------------------------
package ple_pkg;

   // Fixed field widths of the request and response items.
   localparam int KIND_W   = 2;
   localparam int POS_W    = 5;
   localparam int ITEM_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // Default number of list entries.
   localparam int DEF_CAPACITY = 16;

   // Request kinds.
   typedef enum logic [KIND_W-1:0] {
      REQ_INSERT  = 2'd0,
      REQ_REMOVE  = 2'd1,
      REQ_READ    = 2'd2,
      REQ_UNKNOWN = 2'd3
   } req_kind_type;

   // Response status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_BAD_POS = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   // What a cell loads at the next clock edge.
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_FROM_PREV,
      CELL_FROM_NEXT
   } cell_op_type;

   // Control word sent from the list controller to each cell.
   typedef struct packed {
      cell_op_type op;
      logic        read_sel;
   } cell_ctrl_type;

endpackage

/* src/ple_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine channels
// Valid/ready channels for request items and response items.
// ----------------------------------------------------------------------------
interface ple_req_if
   import ple_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] req_type;
   logic [POS_W-1:0]  position;
   logic [ITEM_W-1:0] item_data;

   modport source (output valid, output req_type, output position, output item_data,
                   input ready);
   modport sink   (input valid, input req_type, input position, input item_data,
                   output ready);
endinterface

interface ple_rsp_if
   import ple_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [ITEM_W-1:0]   item_out;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  count;
   logic                is_empty;

   modport source (output valid, output item_out, output status, output count,
                   output is_empty, input ready);
   modport sink   (input valid, input item_out, input status, input count,
                   input is_empty, output ready);
endinterface

/* src/ple_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list cell
// Holds one list entry; loads new data or a neighbor's entry, or holds.
// ----------------------------------------------------------------------------
module ple_cell
   import ple_pkg::*;
(
   input  logic              clock,
   input  cell_ctrl_type     ctrl,
   input  logic [ITEM_W-1:0] new_data,
   input  logic [ITEM_W-1:0] prev_data,
   input  logic [ITEM_W-1:0] next_data,
   output logic [ITEM_W-1:0] data_out,
   output logic [ITEM_W-1:0] tap_out
);

   logic [ITEM_W-1:0] data_ff;
   logic [ITEM_W-1:0] data_in;

   // Pick the next entry value.
   always_comb begin
      unique case (ctrl.op)
         CELL_LOAD:      data_in = new_data;
         CELL_FROM_PREV: data_in = prev_data;
         CELL_FROM_NEXT: data_in = next_data;
         default:        data_in = data_ff;
      endcase
   end

   // Entry storage needs no reset; only written entries are ever read.
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // The entry is passed to the read-out OR only when this cell is addressed.
   assign data_out = data_ff;
   assign tap_out  = ctrl.read_sel ? data_ff : '0;

endmodule

/* src/positional_list_engine_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine
// Ordered list of item words with insert, remove and read at a position.
//
//   Channel  Direction  Handshake    Payload
//   req_if   in         valid/ready  req_type, position, item_data
//   rsp_if   out        valid/ready  item_out, status, count, is_empty
//
// All cells shift or hold in parallel, so one request per cycle is sustained
// while responses are taken.
// A response is held in an output register; a new request is accepted when
// that register is empty or is being drained in the same cycle.
// Reset clears the item count and the response valid flag; entries are not
// cleared and are read only after they were written.
// ----------------------------------------------------------------------------
module positional_list_engine_top
   import ple_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
)(
   input logic       clock,
   input logic       reset,
   ple_req_if.sink   req_if,
   ple_rsp_if.source rsp_if
);

   localparam int CntW = $clog2(CAPACITY + 1);
   localparam int CmpW = (CntW > POS_W) ? CntW : POS_W;

   logic [CntW-1:0]     count_ff;
   logic [CntW-1:0]     count_in;
   logic                rsp_valid_ff;
   logic [ITEM_W-1:0]   rsp_item_ff;
   status_type          rsp_status_ff;
   logic [CntW-1:0]     rsp_count_ff;

   logic                accept;
   req_kind_type        kind;
   logic [CmpW-1:0]     pos_ext;
   logic [CmpW-1:0]     cnt_ext;
   logic                is_full;
   logic                do_ins;
   logic                do_rem;
   logic                do_out;
   status_type          status_val;
   logic [ITEM_W-1:0]   item_val;
   logic [ITEM_W-1:0]   read_val;

   cell_ctrl_type       cell_ctrl [CAPACITY];
   logic [ITEM_W-1:0]   cell_data [CAPACITY];
   logic [ITEM_W-1:0]   cell_tap  [CAPACITY];

   // Handshake: accept when the response register is free or draining.
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   assign kind    = req_kind_type'(req_if.req_type);
   assign pos_ext = CmpW'(req_if.position);
   assign cnt_ext = CmpW'(count_ff);
   assign is_full = (count_ff == CntW'(CAPACITY));

   // Read-out: OR of the addressed cell's tap.
   always_comb begin
      read_val = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_val = read_val | cell_tap[i];
      end
   end

   // Request decode: range and capacity checks.
   always_comb begin
      do_ins     = 1'b0;
      do_rem     = 1'b0;
      do_out     = 1'b0;
      status_val = ST_BAD_POS;
      unique case (kind)
         REQ_INSERT: begin
            priority if (pos_ext > cnt_ext) begin
               status_val = ST_BAD_POS;
            end else if (is_full) begin
               status_val = ST_FULL;
            end else begin
               status_val = ST_OK;
               do_ins     = 1'b1;
            end
         end
         REQ_REMOVE: begin
            if (pos_ext < cnt_ext) begin
               status_val = ST_OK;
               do_out     = 1'b1;
               do_rem     = 1'b1;
            end
         end
         REQ_READ: begin
            if (pos_ext < cnt_ext) begin
               status_val = ST_OK;
               do_out     = 1'b1;
            end
         end
         default: begin
            status_val = ST_BAD_POS;
         end
      endcase
   end

   // The addressed entry is returned only by a good remove or read.
   assign item_val = do_out ? read_val : '0;

   // Next item count.
   always_comb begin
      count_in = count_ff;
      if (accept && do_ins) begin
         count_in = count_ff + CntW'(1);
      end else if (accept && do_rem) begin
         count_in = count_ff - CntW'(1);
      end
   end

   // Per-cell control: shift up above an insert, shift down from a remove.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cell_ctrl[i].read_sel = (CmpW'(i) == pos_ext);
         cell_ctrl[i].op       = CELL_HOLD;
         if (accept && do_ins) begin
            if (CmpW'(i) > pos_ext) begin
               cell_ctrl[i].op = CELL_FROM_PREV;
            end else if (CmpW'(i) == pos_ext) begin
               cell_ctrl[i].op = CELL_LOAD;
            end
         end else if (accept && do_rem) begin
            if (CmpW'(i) >= pos_ext) begin
               cell_ctrl[i].op = CELL_FROM_NEXT;
            end
         end
      end
   end

   // Chain of cells, head at index zero.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [ITEM_W-1:0] prev_data;
      logic [ITEM_W-1:0] next_data;

      if (g == 0) begin : g_head
         assign prev_data = '0;
      end else begin : g_mid_prev
         assign prev_data = cell_data[g-1];
      end

      if (g == CAPACITY - 1) begin : g_tail
         assign next_data = '0;
      end else begin : g_mid_next
         assign next_data = cell_data[g+1];
      end

      ple_cell u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl[g]),
         .new_data  (req_if.item_data),
         .prev_data (prev_data),
         .next_data (next_data),
         .data_out  (cell_data[g]),
         .tap_out   (cell_tap[g])
      );
   end

   // Control state: item count and response valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_item_ff   <= item_val;
         rsp_status_ff <= status_val;
         rsp_count_ff  <= count_in;
      end
   end

   // Response outputs; count carries its low bits only.
   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.item_out = rsp_item_ff;
   assign rsp_if.status   = rsp_status_ff;
   assign rsp_if.count    = COUNT_W'(CmpW'(rsp_count_ff));
   assign rsp_if.is_empty = (rsp_count_ff == '0);

endmodule

/* test/ple_list_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list checker
// Watches the request and response channels of the positional list engine.
// Every accepted request is applied to a local copy of the list, and the
// answer it should produce is queued. Each accepted response is compared
// field by field with the oldest queued answer. The failure count, the number
// of answers still due and the current list length go back to the bench top.
// ----------------------------------------------------------------------------
module ple_list_checker
   import ple_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
)(
   input  logic        clock,
   input  logic        reset,
   ple_req_if          req_mon,
   ple_rsp_if          rsp_mon,
   output int unsigned fail_count,
   output int unsigned pending_answers,
   output int unsigned list_length
);

   // One answer as the engine should return it.
   typedef struct {
      logic [ITEM_W-1:0]  item;
      status_type         status;
      logic [COUNT_W-1:0] count;
      logic               is_empty;
   } list_answer_type;

   logic [ITEM_W-1:0] list_words [CAPACITY];
   int unsigned       stored_items;
   list_answer_type   answer_q [$];
   list_answer_type   due_answer;

   // Apply one request to the local list and return the answer it causes.
   function automatic list_answer_type apply_request(req_kind_type kind,
                                                     int unsigned pos,
                                                     logic [ITEM_W-1:0] data);
      list_answer_type ans;
      int unsigned     i;
      ans.item   = '0;
      ans.status = ST_OK;
      case (kind)
         REQ_INSERT: begin
            // The position check wins over the full check.
            if (pos > stored_items) begin
               ans.status = ST_BAD_POS;
            end else if (stored_items >= CAPACITY) begin
               ans.status = ST_FULL;
            end else begin
               for (i = stored_items; i > pos; i--) begin
                  list_words[i] = list_words[i-1];
               end
               list_words[pos] = data;
               stored_items++;
            end
         end
         REQ_REMOVE: begin
            if (pos >= stored_items) begin
               ans.status = ST_BAD_POS;
            end else begin
               ans.item = list_words[pos];
               for (i = pos; i + 1 < stored_items; i++) begin
                  list_words[i] = list_words[i+1];
               end
               stored_items--;
            end
         end
         REQ_READ: begin
            if (pos >= stored_items) begin
               ans.status = ST_BAD_POS;
            end else begin
               ans.item = list_words[pos];
            end
         end
         default: begin
            // An unknown request leaves the list alone.
            ans.status = ST_BAD_POS;
         end
      endcase
      ans.count    = COUNT_W'(stored_items);
      ans.is_empty = (stored_items == 0);
      return ans;
   endfunction

   // Compare responses first, then queue the answer of a new request.
   always @(posedge clock) begin
      if (reset) begin
         answer_q.delete();
         stored_items = 0;
         fail_count   = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (answer_q.size() == 0) begin
               fail_count++;
               $display("%0t: response item with no answer due: item %h status %0d",
                        $time, rsp_mon.item_out, rsp_mon.status);
            end else begin
               due_answer = answer_q.pop_front();
               if (rsp_mon.item_out !== due_answer.item) begin
                  fail_count++;
                  $display("%0t: item_out expected %h actual %h",
                           $time, due_answer.item, rsp_mon.item_out);
               end
               if (rsp_mon.status !== due_answer.status) begin
                  fail_count++;
                  $display("%0t: status expected %0d actual %0d",
                           $time, due_answer.status, rsp_mon.status);
               end
               if (rsp_mon.count !== due_answer.count) begin
                  fail_count++;
                  $display("%0t: count expected %0d actual %0d",
                           $time, due_answer.count, rsp_mon.count);
               end
               if (rsp_mon.is_empty !== due_answer.is_empty) begin
                  fail_count++;
                  $display("%0t: is_empty expected %0b actual %0b",
                           $time, due_answer.is_empty, rsp_mon.is_empty);
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            answer_q.push_back(apply_request(req_kind_type'(req_mon.req_type),
                                             32'(req_mon.position),
                                             req_mon.item_data));
         end
      end
      pending_answers = answer_q.size();
      list_length     = stored_items;
   end

endmodule

/* test/tb_positional_list_engine_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine testbench
// Drives request items into the engine and takes response items with random
// gaps on both sides. A directed part covers the empty and full list, bad
// positions, the unknown request and head, middle and tail access; a random
// part then swings the list between empty and full. The checker beside the
// engine predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_positional_list_engine_top;
   import ple_pkg::*;

   localparam int CAPACITY    = DEF_CAPACITY;
   localparam int RANDOM_ITEMS = 1100;
   localparam int STALL_LIMIT = 1000;

   logic        clock;
   logic        reset;
   logic        calm;
   int unsigned fail_count;
   int unsigned pending_answers;
   int unsigned list_length;
   int unsigned stall_cycles;
   int          n;

   ple_req_if req_chan ();
   ple_rsp_if rsp_chan ();

   positional_list_engine_top #(
      .CAPACITY (CAPACITY)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan),
      .rsp_if (rsp_chan)
   );

   ple_list_checker #(
      .CAPACITY (CAPACITY)
   ) list_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .fail_count      (fail_count),
      .pending_answers (pending_answers),
      .list_length     (list_length)
   );

   // Clock with an 8 ns period.
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // The receiver stalls about a quarter of the time unless the run is calm.
   always @(negedge clock) begin
      rsp_chan.ready <= !reset && (calm || $urandom_range(99) >= 25);
   end

   // Watchdog on cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Present one request item at a falling edge and hold it until accepted.
   task automatic send_request(input req_kind_type kind, input logic [POS_W-1:0] pos,
                               input logic [ITEM_W-1:0] data);
      if (!calm && $urandom_range(99) < 25) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.req_type  <= kind;
      req_chan.position  <= pos;
      req_chan.item_data <= data;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop valid and hold off until every answer has come back.
   task automatic drain_answers();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (pending_answers != 0) @(negedge clock);
   endtask

   // One random request, mostly at a legal position for the current length.
   // A growing phase favors inserts, a shrinking phase favors removes.
   task automatic send_random_request(input bit growing);
      req_kind_type      kind;
      int unsigned       pick;
      logic [POS_W-1:0]  pos;
      pick = $urandom_range(99);
      if (pick < (growing ? 60 : 20)) begin
         kind = REQ_INSERT;
      end else if (pick < 80) begin
         kind = REQ_REMOVE;
      end else if (pick < 97) begin
         kind = REQ_READ;
      end else begin
         kind = REQ_UNKNOWN;
      end
      if ($urandom_range(99) < 10) begin
         pos = POS_W'($urandom_range(31));
      end else if (kind == REQ_INSERT) begin
         pos = POS_W'($urandom_range(list_length));
      end else if (list_length == 0) begin
         pos = '0;
      end else begin
         pos = POS_W'($urandom_range(list_length - 1));
      end
      send_request(kind, pos, $urandom);
   endtask

   initial begin
      reset              = 1'b1;
      calm               = 1'b0;
      stall_cycles       = 0;
      req_chan.valid     = 1'b0;
      req_chan.req_type  = REQ_INSERT;
      req_chan.position  = '0;
      req_chan.item_data = '0;
      rsp_chan.ready     = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Access to an empty list, then head, tail and middle work.
      send_request(REQ_READ, 5'd0, 32'h0);
      send_request(REQ_REMOVE, 5'd0, 32'h0);
      send_request(REQ_INSERT, 5'd1, 32'hDEAD_BEEF);
      send_request(REQ_INSERT, 5'd0, 32'hFFFF_FFFF);
      send_request(REQ_INSERT, 5'd1, 32'h0000_0000);
      send_request(REQ_INSERT, 5'd0, 32'hA5A5_A5A5);
      send_request(REQ_INSERT, 5'd3, 32'h5A5A_5A5A);
      send_request(REQ_READ, 5'd3, 32'h0);
      send_request(REQ_UNKNOWN, 5'd31, 32'hFFFF_FFFF);
      send_request(REQ_REMOVE, 5'd1, 32'h0);

      // Fill the list, then hit it with a full insert and a bad position.
      while (list_length < CAPACITY) begin
         send_request(REQ_INSERT, POS_W'($urandom_range(list_length)), $urandom);
      end
      send_request(REQ_INSERT, POS_W'(CAPACITY), 32'h1234_5678);
      send_request(REQ_INSERT, POS_W'(CAPACITY + 1), 32'h8765_4321);
      send_request(REQ_REMOVE, POS_W'(CAPACITY - 1), 32'h0);
      send_request(REQ_REMOVE, 5'd0, 32'h0);
      drain_answers();

      // Random part with alternating growth phases and one calm stretch.
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         calm = (n >= 400 && n < 600);
         if (n > 0 && n % 250 == 0) begin
            drain_answers();
         end
         send_random_request((n / 40) % 2 == 0);
      end
      calm = 1'b0;

      drain_answers();
      repeat (5) @(negedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
